// File: hw/rtl/range_weighted_window_average_macros.svh
// Assertion macros used by the range weighted window average checker.
`ifndef RANGE_WEIGHTED_WINDOW_AVERAGE_MACROS_SVH
`define RANGE_WEIGHTED_WINDOW_AVERAGE_MACROS_SVH

// Same-cycle implication, sampled on clk, quiet while rst_n is low
`define RWWA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rwwa assertion failed");

// Next-cycle implication, sampled on clk, quiet while rst_n is low
`define RWWA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rwwa assertion failed");

`endif

// File: hw/rtl/rwwa_pkg.sv
// Package: shared types and constants of the range weighted window average.
`default_nettype none
package rwwa_pkg;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_RADIUS = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RANGE_LIMIT   = 2'd3;

  // Field widths
  localparam int SIZE_W   = 9;
  localparam int RADIUS_W = 3;
  localparam int PIX_W    = 8;
  localparam int COORD_W  = 8;

  // Register reset values
  localparam logic [SIZE_W-1:0]   RST_IMAGE_WIDTH   = 9'd256;
  localparam logic [SIZE_W-1:0]   RST_IMAGE_HEIGHT  = 9'd256;
  localparam logic [RADIUS_W-1:0] RST_WINDOW_RADIUS = 3'd1;
  localparam logic [PIX_W-1:0]    RST_RANGE_LIMIT   = 8'd15;

  // Command codes
  localparam logic CMD_STORE   = 1'b0;
  localparam logic CMD_COMPUTE = 1'b1;

  // Sequencer states
  typedef enum logic [13:0] {
    ST_IDLE  = 14'b00000000000001,
    ST_XGO   = 14'b00000000000010,
    ST_XWAIT = 14'b00000000000100,
    ST_YGO   = 14'b00000000001000,
    ST_YWAIT = 14'b00000000010000,
    ST_WRITE = 14'b00000000100000,
    ST_CRD   = 14'b00000001000000,
    ST_CWAIT = 14'b00000010000000,
    ST_BACK  = 14'b00000100000000,
    ST_SCAN  = 14'b00001000000000,
    ST_DRAIN = 14'b00010000000000,
    ST_DGO   = 14'b00100000000000,
    ST_DWAIT = 14'b01000000000000,
    ST_OUT   = 14'b10000000000000
  } state_t;

endpackage
`default_nettype wire

// File: hw/rtl/rwwa_div.sv
// Restoring radix-2 divider: one quotient bit per cycle.
`default_nettype none
module rwwa_div import rwwa_pkg::*; #(
  parameter int N = 16,
  parameter int M = 10
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  input  wire logic [N-1:0] dividend,
  input  wire logic [M-1:0] divisor,
  output logic              done,
  output logic [N-1:0]      quotient,
  output logic [M-1:0]      remainder
);

  localparam int CNT_W = $clog2(N + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N-1:0]     quo_r;
  logic [M-1:0]     rem_r;
  logic [M-1:0]     div_r;
  logic [M:0]       trial;
  logic [M:0]       diff;
  logic             ge;

  // Shift in the next dividend bit and test against the divisor
  always_comb begin
    trial = {rem_r, quo_r[N-1]};
    diff  = trial - {1'b0, div_r};
    ge    = (trial >= {1'b0, div_r});
  end

  // Control: count N steps, pulse done at the end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(N - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      div_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[N-2:0], ge};
      rem_r <= ge ? diff[M-1:0] : trial[M-1:0];
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule
`default_nettype wire

// File: hw/rtl/range_weighted_window_average.sv
// A store writes memory; a compute wraps the coordinates, reads the centre, scans and divides.
// One shared divider; accumulator and dividend are SUM_W bits (16 at the default radius limit).
// Throughput: one request at a time; window reads go one pixel per cycle from the frame memory.
// A finished result waits in the output register while the next request is taken.
// Reset: synchronous rst_n clears control and loads register defaults; frame memory is not
// cleared and needs no clearing pass.
`default_nettype none
module range_weighted_window_average import rwwa_pkg::*; #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256,
  parameter int MAX_RADIUS = 7
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic                  in_command,
  input  wire logic [COORD_W-1:0]    in_col,
  input  wire logic [COORD_W-1:0]    in_row,
  input  wire logic [PIX_W-1:0]      in_pixel_in,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [PIX_W-1:0]           out_filtered_pixel,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int XW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW     = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int SMAX   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int SW     = $clog2(SMAX + 1);
  localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW     = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int WIN    = (2 * MAX_RADIUS + 1) * (2 * MAX_RADIUS + 1);
  localparam int SUM_W  = $clog2(WIN * 255 + 1);
  localparam int CW     = $clog2(WIN + 1);
  localparam int DIV_N  = SUM_W;
  localparam int DIV_M  = (CW > SW) ? CW : SW;
  // Reciprocals for reducing an 8-bit store address by the frame limits
  localparam int X_RECIP = 65536 / MAX_WIDTH + 1;
  localparam int Y_RECIP = 65536 / MAX_HEIGHT + 1;

  // Configuration registers
  logic [SIZE_W-1:0]   width_r;
  logic [SIZE_W-1:0]   height_r;
  logic [RADIUS_W-1:0] radius_r;
  logic [PIX_W-1:0]    limit_r;

  // Sequencer and working registers
  state_t            state_r, state_nxt;
  logic [COORD_W-1:0] col_r;
  logic [COORD_W-1:0] row_r;
  logic [PIX_W-1:0]  pix_r;
  logic [XW-1:0]     x_r;
  logic [XW-1:0]     x0_r;
  logic [YW-1:0]     y_r;
  logic [PIX_W-1:0]  centre_r;
  logic [RW:0]       bcnt_r;
  logic [RW:0]       icnt_r;
  logic [RW:0]       jcnt_r;
  logic              pend_r;
  logic [SUM_W-1:0]  sum_r;
  logic [CW-1:0]     cnt_r;
  logic              out_valid_r;
  logic [PIX_W-1:0]  out_pix_r;

  // Frame memory
  logic [PIX_W-1:0]  mem [DEPTH];
  logic [PIX_W-1:0]  rdata_r;
  logic [AW-1:0]     addr;
  logic              we;

  // Effective sizes
  logic [SW-1:0]     w_eff;
  logic [SW-1:0]     h_eff;
  logic [RW-1:0]     r_eff;
  logic [RW:0]       side_last;
  logic [XW-1:0]     x_inc, x_dec;
  logic [YW-1:0]     y_inc, y_dec;

  // Store address reduction
  logic [31:0]       st_xq;
  logic [31:0]       st_yq;
  logic [XW-1:0]     st_x;
  logic [YW-1:0]     st_y;

  // Divider hookup
  logic              div_start;
  logic [DIV_N-1:0]  div_dividend;
  logic [DIV_M-1:0]  div_divisor;
  logic              div_done;
  logic [DIV_N-1:0]  div_quo;
  logic [DIV_M-1:0]  div_rem;

  // Range test
  logic [PIX_W-1:0]  pdiff;
  logic              in_range;
  logic              out_free;

  // Clamp the frame size and radius
  always_comb begin
    if (width_r == '0) begin
      w_eff = SW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      w_eff = SW'(MAX_WIDTH);
    end else begin
      w_eff = SW'(width_r);
    end
    if (height_r == '0) begin
      h_eff = SW'(1);
    end else if (32'(height_r) > MAX_HEIGHT) begin
      h_eff = SW'(MAX_HEIGHT);
    end else begin
      h_eff = SW'(height_r);
    end
    if (32'(radius_r) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(radius_r);
    end
    side_last = {r_eff, 1'b0};
  end

  // Reduce the store address by the frame limits with a reciprocal multiply
  always_comb begin
    st_xq = (32'(in_col) * 32'(X_RECIP)) >> 16;
    st_yq = (32'(in_row) * 32'(Y_RECIP)) >> 16;
    st_x  = XW'(32'(in_col) - st_xq * 32'(MAX_WIDTH));
    st_y  = YW'(32'(in_row) - st_yq * 32'(MAX_HEIGHT));
  end

  // Wrapped neighbor coordinates
  always_comb begin
    x_inc = ((SW'(x_r) + 1'b1) == w_eff) ? '0 : x_r + 1'b1;
    y_inc = ((SW'(y_r) + 1'b1) == h_eff) ? '0 : y_r + 1'b1;
    x_dec = (x_r == '0) ? XW'(w_eff - 1'b1) : x_r - 1'b1;
    y_dec = (y_r == '0) ? YW'(h_eff - 1'b1) : y_r - 1'b1;
  end

  // Memory address and write enable
  assign addr = AW'(AW'(y_r) * AW'(MAX_WIDTH)) + AW'(x_r);
  assign we   = (state_r == ST_WRITE);

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= pix_r;
    end
    rdata_r <= mem[addr];
  end

  // Divider operand select
  always_comb begin
    div_start = (state_r == ST_XGO) || (state_r == ST_YGO) || (state_r == ST_DGO);
    case (state_r)
      ST_XGO: begin
        div_dividend = DIV_N'(col_r);
        div_divisor  = DIV_M'(w_eff);
      end
      ST_YGO: begin
        div_dividend = DIV_N'(row_r);
        div_divisor  = DIV_M'(h_eff);
      end
      default: begin
        div_dividend = sum_r;
        div_divisor  = DIV_M'(cnt_r);
      end
    endcase
  end

  rwwa_div #(
    .N(DIV_N),
    .M(DIV_M)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  // Compare the returned pixel with the centre
  always_comb begin
    pdiff    = (rdata_r > centre_r) ? rdata_r - centre_r : centre_r - rdata_r;
    in_range = (pdiff <= limit_r);
    out_free = !out_valid_r || !out_stall;
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) state_nxt = (in_command == CMD_COMPUTE) ? ST_XGO : ST_WRITE;
      end
      ST_XGO:   state_nxt = ST_XWAIT;
      ST_XWAIT: if (div_done) state_nxt = ST_YGO;
      ST_YGO:   state_nxt = ST_YWAIT;
      ST_YWAIT: if (div_done) state_nxt = ST_CRD;
      ST_WRITE: state_nxt = ST_IDLE;
      ST_CRD:   state_nxt = ST_CWAIT;
      ST_CWAIT: state_nxt = ST_BACK;
      ST_BACK:  if (bcnt_r == {1'b0, r_eff}) state_nxt = ST_SCAN;
      ST_SCAN: begin
        if ((jcnt_r == side_last) && (icnt_r == side_last)) state_nxt = ST_DRAIN;
      end
      ST_DRAIN: state_nxt = ST_DGO;
      ST_DGO:   state_nxt = ST_DWAIT;
      ST_DWAIT: if (div_done) state_nxt = ST_OUT;
      ST_OUT:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Control registers: state, config, output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      width_r     <= RST_IMAGE_WIDTH;
      height_r    <= RST_IMAGE_HEIGHT;
      radius_r    <= RST_WINDOW_RADIUS;
      limit_r     <= RST_RANGE_LIMIT;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pend_r  <= (state_r == ST_SCAN);
      if (cfg_valid) begin
        case (cfg_index)
          REG_IMAGE_WIDTH:   width_r  <= cfg_data;
          REG_IMAGE_HEIGHT:  height_r <= cfg_data;
          REG_WINDOW_RADIUS: radius_r <= cfg_data[RADIUS_W-1:0];
          REG_RANGE_LIMIT:   limit_r  <= cfg_data[PIX_W-1:0];
          default: ;
        endcase
      end
      if ((state_r == ST_OUT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Working datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        col_r <= in_col;
        row_r <= in_row;
        pix_r <= in_pixel_in;
        x_r   <= st_x;
        y_r   <= st_y;
      end
      ST_XWAIT: if (div_done) x_r <= XW'(div_rem);
      ST_YWAIT: if (div_done) y_r <= YW'(div_rem);
      ST_CWAIT: begin
        centre_r <= rdata_r;
        bcnt_r   <= '0;
        sum_r    <= '0;
        cnt_r    <= '0;
      end
      ST_BACK: begin
        if (bcnt_r == {1'b0, r_eff}) begin
          x0_r   <= x_r;
          icnt_r <= '0;
          jcnt_r <= '0;
        end else begin
          x_r    <= x_dec;
          y_r    <= y_dec;
          bcnt_r <= bcnt_r + 1'b1;
        end
      end
      ST_SCAN: begin
        if (jcnt_r == side_last) begin
          jcnt_r <= '0;
          x_r    <= x0_r;
          y_r    <= y_inc;
          icnt_r <= icnt_r + 1'b1;
        end else begin
          jcnt_r <= jcnt_r + 1'b1;
          x_r    <= x_inc;
        end
      end
      ST_OUT: if (out_free) out_pix_r <= div_quo[PIX_W-1:0];
      default: ;
    endcase
    // Accumulate the pixel read in the previous cycle
    if (pend_r && in_range) begin
      sum_r <= sum_r + SUM_W'(rdata_r);
      cnt_r <= cnt_r + 1'b1;
    end
  end

  assign in_stall           = (state_r != ST_IDLE);
  assign out_valid          = out_valid_r;
  assign out_filtered_pixel = out_pix_r;
  assign cfg_ready          = 1'b1;

endmodule
`default_nettype wire

// File: hw/rtl/rwwa_checker.sv
// Checker: port-level properties of the range weighted window average, with its bind.
`default_nettype none
`include "range_weighted_window_average_macros.svh"
module rwwa_checker import rwwa_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_stall,
  input wire logic                  in_command,
  input wire logic [COORD_W-1:0]    in_col,
  input wire logic [COORD_W-1:0]    in_row,
  input wire logic [PIX_W-1:0]      in_pixel_in,
  input wire logic                  out_valid,
  input wire logic                  out_stall,
  input wire logic [PIX_W-1:0]      out_filtered_pixel,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready,
  input wire logic [CFG_IDX_W-1:0]  cfg_index,
  input wire logic [CFG_DATA_W-1:0] cfg_data
);

  // A taken request keeps the block busy for at least the next cycle
  `RWWA_ASSERT_NEXT(a_busy_after_req, in_valid && !in_stall, in_stall)

  // A store request never brings out a result right after it
  `RWWA_ASSERT_NEXT(a_store_silent, in_valid && !in_stall && (in_command == CMD_STORE), !$rose(out_valid))

  // A new result only comes out of a request in progress
  `RWWA_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall))

  // A stalled result holds
  `RWWA_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_filtered_pixel))

endmodule

bind range_weighted_window_average rwwa_checker u_rwwa_checker (.*);
`default_nettype wire

// File: tb/sv/tb_range_weighted_window_average.sv
// Testbench for the range weighted window average filter: directed and random requests checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none

import rwwa_pkg::*;

// Frame predictor and queue of expected filtered pixels
class window_average_board;
  logic [PIX_W-1:0] frame [0:65535];
  int unsigned img_w, img_h, radius, limit;
  logic [PIX_W-1:0] pending [$];
  int errors;

  function new();
    img_w = RST_IMAGE_WIDTH;
    img_h = RST_IMAGE_HEIGHT;
    radius = RST_WINDOW_RADIUS;
    limit = RST_RANGE_LIMIT;
    errors = 0;
  endfunction

  function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    case (idx)
      REG_IMAGE_WIDTH: img_w = val;
      REG_IMAGE_HEIGHT: img_h = val;
      REG_WINDOW_RADIUS: radius = val[2:0];
      default: limit = val[7:0];
    endcase
  endfunction

  // Note one accepted request; a compute queues its expected average
  function void note_request(logic cmd, logic [7:0] c, logic [7:0] r, logic [7:0] p);
    int w, h, rad, cx, cy, x, y, i, j;
    int unsigned centre, sum, cnt, pv, d;
    if (cmd == CMD_STORE) begin
      frame[{r, c}] = p;
      return;
    end
    w = (img_w == 0) ? 1 : (img_w > 256 ? 256 : img_w);
    h = (img_h == 0) ? 1 : (img_h > 256 ? 256 : img_h);
    rad = radius;
    cx = c % w;
    cy = r % h;
    centre = frame[cy * 256 + cx];
    sum = 0;
    cnt = 0;
    for (i = -rad; i <= rad; i++) begin
      y = (cy + i) % h;
      if (y < 0) y += h;
      for (j = -rad; j <= rad; j++) begin
        x = (cx + j) % w;
        if (x < 0) x += w;
        pv = frame[y * 256 + x];
        d = (pv > centre) ? pv - centre : centre - pv;
        if (d <= limit) begin
          sum += pv;
          cnt++;
        end
      end
    end
    pending.push_back(sum / cnt);
  endfunction

  function void check_result(logic [PIX_W-1:0] got);
    logic [PIX_W-1:0] want;
    if (pending.size() == 0) begin
      report_bad($sformatf("unexpected result %0d", got));
      return;
    end
    want = pending.pop_front();
    if (got !== want) report_bad($sformatf("filtered_pixel got %0d want %0d", got, want));
  endfunction

  function void report_bad(string msg);
    errors++;
    if (errors <= 30) $display("MISMATCH: %s", msg);
  endfunction
endclass

module tb_range_weighted_window_average;
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_command = 1'b0;
  logic [COORD_W-1:0] in_col = '0;
  logic [COORD_W-1:0] in_row = '0;
  logic [PIX_W-1:0] in_pixel_in = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [PIX_W-1:0] out_filtered_pixel;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  window_average_board board;
  longint cycles = 0;
  bit hold_off = 1'b0;
  bit written [0:65535];
  int wr_cols, wr_rows;

  range_weighted_window_average uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_command(in_command),
    .in_col(in_col), .in_row(in_row), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_filtered_pixel(out_filtered_pixel),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #1 clk = ~clk;

  // Count cycles and stop at the limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Check each accepted result
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_filtered_pixel);
  end

  // Stall the result side at random; hold off long when asked
  always @(posedge clk) begin
    int k;
    k = $urandom_range(0, 99);
    if (hold_off) out_stall <= 1'b1;
    else if (k < 3) out_stall <= 1'b1;
    else if (k < 25) out_stall <= ($urandom_range(0, 1) == 1);
    else out_stall <= 1'b0;
  end

  // Drop valid only when a real gap follows
  task automatic idle_gap();
    int n, k;
    k = $urandom_range(0, 99);
    if (k < 60) n = 0;
    else if (k < 95) n = $urandom_range(1, 3);
    else n = $urandom_range(10, 60);
    if (n > 0) in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Send one request and hold it until accepted
  task automatic send_request(logic cmd, logic [7:0] c, logic [7:0] r, logic [7:0] p);
    in_valid <= 1'b1;
    in_command <= cmd;
    in_col <= c;
    in_row <= r;
    in_pixel_in <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_request(cmd, c, r, p);
    if (cmd == CMD_STORE) written[{r, c}] = 1'b1;
  endtask

  task automatic store_px(int c, int r, int p);
    send_request(CMD_STORE, c[7:0], r[7:0], p[7:0]);
    idle_gap();
  endtask

  task automatic compute_px(int c, int r);
    send_request(CMD_COMPUTE, c[7:0], r[7:0], 8'($urandom));
    idle_gap();
  endtask

  // Wait until all results are back, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_DATA_W-1:0];
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.set_reg(idx, val[CFG_DATA_W-1:0]);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_frame(int w, int h, int rad, int lim);
    drain();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_WINDOW_RADIUS, rad);
    write_reg(REG_RANGE_LIMIT, lim);
  endtask

  // Fill the whole w x h frame in use so every window read hits a written pixel
  task automatic fill_frame(int w, int h, int base, int spread);
    int x, y;
    for (y = 0; y < h; y++)
      for (x = 0; x < w; x++)
        if (!written[y * 256 + x] || $urandom_range(0, 3) == 0)
          store_px(x, y, (base + $urandom_range(0, spread)) & 255);
  endtask

  // Random phase: mostly computes over the filled frame, some overwrites
  task automatic random_phase(int w, int h, int n);
    int i, k;
    for (i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 30) store_px($urandom_range(0, w - 1), $urandom_range(0, h - 1), $urandom);
      else compute_px($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  initial begin
    int ph;
    int ws [6] = '{8, 16, 1, 12, 5, 3};
    int hs [6] = '{8, 1, 16, 12, 3, 5};
    board = new();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: small frame, extremes of registers and fields
    set_frame(4, 4, 1, 15);
    fill_frame(4, 4, 0, 255);
    store_px(0, 0, 0);
    store_px(3, 3, 255);
    compute_px(0, 0);
    compute_px(255, 255);
    compute_px(3, 3);
    set_frame(0, 0, 7, 0);
    compute_px(170, 85);
    set_frame(4, 4, 7, 255);
    compute_px(1, 2);
    set_frame(4, 4, 0, 255);
    compute_px(2, 1);
    set_frame(4, 4, 2, 0);
    compute_px(0, 3);
    set_frame(300, 2, 1, 40);
    store_px(255, 0, 200);
    store_px(255, 1, 210);
    fill_frame(256, 2, 100, 60);

    // Long hold-off on the result side while requests keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (3000) @(posedge clk);
        hold_off = 1'b0;
      end
      random_phase(256, 2, 40);
    join

    // Random phases over several frame settings
    for (ph = 0; ph < 6; ph++) begin
      set_frame(ws[ph], hs[ph], $urandom_range(0, 7), (ph == 2) ? 255 : $urandom_range(0, 80));
      fill_frame(ws[ph], hs[ph], $urandom_range(0, 255), $urandom_range(0, 255));
      random_phase(ws[ph], hs[ph], 110);
    end

    drain();
    if (board.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

`default_nettype wire
